// ===== rtl/core/tcat_pkg.sv =====
// shared types and constants for the three-channel alarm timer
package tcat_pkg;

	localparam int NUM_ALARMS = 3;
	localparam int CHAN_W     = 2;
	localparam int HALF_W     = 16;
	localparam int TIME_W     = 32;
	localparam int THR_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SET    = 2'd1,
		OP_CANCEL = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_TIME_MASK = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		op_t                 operation;
		logic [CHAN_W-1:0]   channel;
		logic [TIME_W-1:0]   ticks;
		logic [TIME_W-1:0]   param;
	} item_t;

	typedef struct packed {
		logic [THR_W-1:0]    threshold;
		logic [TIME_W-1:0]   time_mask;
	} cfg_t;

	typedef struct packed {
		logic                  fired;
		logic [CHAN_W-1:0]     fired_channel;
		logic [TIME_W-1:0]     fired_param;
		logic [TIME_W-1:0]     time_value;
		logic [NUM_ALARMS-1:0] enables;
	} res_t;

endpackage

// ===== rtl/core/tcat_engine.sv =====
// alarm timer state and single-pass item evaluation
module tcat_engine import tcat_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  go,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	logic [HALF_W-1:0]     counter_q, counter_d;
	logic [HALF_W-1:0]     last_sample_q, last_sample_d;
	logic [HALF_W-1:0]     high_count_q, high_count_d;
	logic [HALF_W-1:0]     compare_q [NUM_ALARMS];
	logic [HALF_W-1:0]     compare_d [NUM_ALARMS];
	logic [TIME_W-1:0]     param_q [NUM_ALARMS];
	logic [TIME_W-1:0]     param_d [NUM_ALARMS];
	logic [NUM_ALARMS-1:0] pend_q, pend_d;
	logic [NUM_ALARMS-1:0] en_q, en_d;

	logic [HALF_W-1:0]     cnt_inc;
	logic [NUM_ALARMS-1:0] hit;
	logic [NUM_ALARMS-1:0] due;
	logic [NUM_ALARMS-1:0] low;
	logic [NUM_ALARMS-1:0] chm;
	logic [TIME_W-1:0]     low_param;
	logic [CHAN_W-1:0]     low_chan;
	logic                  chan_ok;
	logic                  immediate;
	logic [HALF_W-1:0]     hc_next;

	always_comb begin
		cnt_inc   = counter_q + 1'b1;
		low_param = '0;
		low_chan  = '0;
		for (int n = 0; n < NUM_ALARMS; n++) begin
			hit[n] = (compare_q[n] == cnt_inc);
			chm[n] = (CHAN_W'(n) == item.channel);
		end
		due = (pend_q | hit) & en_q;
		// isolate the lowest set bit
		low = due & (~due + 1'b1);
		for (int n = 0; n < NUM_ALARMS; n++) begin
			if (low[n]) begin
				low_param = param_q[n];
				low_chan  = CHAN_W'(n);
			end
		end
		chan_ok   = (item.channel < CHAN_W'(NUM_ALARMS));
		immediate = (item.ticks <= {{(TIME_W-THR_W){1'b0}}, cfg.threshold});
		hc_next   = (counter_q < last_sample_q) ? high_count_q + 1'b1 : high_count_q;
	end

	always_comb begin
		counter_d     = counter_q;
		last_sample_d = last_sample_q;
		high_count_d  = high_count_q;
		compare_d     = compare_q;
		param_d       = param_q;
		pend_d        = pend_q;
		en_d          = en_q;
		res           = '0;
		unique case (item.operation)
			OP_TICK: begin
				counter_d = cnt_inc;
				pend_d    = (pend_q | hit) & ~low;
				en_d      = en_q & ~low;
				if (|due) begin
					res.fired         = 1'b1;
					res.fired_channel = low_chan;
					res.fired_param   = low_param;
				end
			end
			OP_SET: begin
				if (chan_ok) begin
					if (immediate) begin
						en_d              = en_q & ~chm;
						res.fired         = 1'b1;
						res.fired_channel = item.channel;
						res.fired_param   = item.param;
					end else begin
						for (int n = 0; n < NUM_ALARMS; n++) begin
							if (chm[n]) begin
								param_d[n]   = item.param;
								compare_d[n] = counter_q + item.ticks[HALF_W-1:0];
							end
						end
						pend_d = pend_q & ~chm;
						en_d   = en_q | chm;
					end
				end
			end
			OP_CANCEL: begin
				if (chan_ok) begin
					pend_d = pend_q & ~chm;
					en_d   = en_q & ~chm;
				end
			end
			OP_READ: begin
				high_count_d   = hc_next;
				last_sample_d  = counter_q;
				res.time_value = {hc_next, counter_q} & cfg.time_mask;
			end
			default: begin
			end
		endcase
		res.enables = en_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q     <= '0;
			last_sample_q <= '0;
			high_count_q  <= '0;
			pend_q        <= '0;
			en_q          <= '0;
			for (int n = 0; n < NUM_ALARMS; n++) begin
				compare_q[n] <= '0;
				param_q[n]   <= '0;
			end
		end else if (go) begin
			counter_q     <= counter_d;
			last_sample_q <= last_sample_d;
			high_count_q  <= high_count_d;
			pend_q        <= pend_d;
			en_q          <= en_d;
			compare_q     <= compare_d;
			param_q       <= param_d;
		end
	end

endmodule

// ===== rtl/core/three_channel_alarm_timer_unit.sv =====
// top level of the three-channel alarm timer
// A 16-bit tick counter with three one-shot compare alarms. Each input
// transfer carries one operation (tick, set alarm, cancel alarm, read time) and
// produces exactly one result transfer. Items are taken at one per clock while
// the output is not stalled: an item sits in the input stage, where the alarm
// state is updated and the result is formed, and the result then waits in the
// output register. A stalled output holds back at most the one item already
// in the input stage. Configuration writes take effect at the next edge and
// are meant to be done while idle.
module three_channel_alarm_timer_unit import tcat_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [TIME_W-1:0]     cfg_data,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // channel, ticks, param, zero pad
	input  logic [1:0]            s_axis_tuser,  // operation
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // fired_channel, fired_param,
	                                             // time_value, enables, zero pad
	output logic [0:0]            m_axis_tuser   // fired
);

	cfg_t  cfg_q;
	item_t item_s1;
	logic  valid_s1;
	logic  advance;
	res_t  res;
	res_t  res_q;
	logic  out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THR_W'(2);
			cfg_q.time_mask <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD: cfg_q.threshold <= cfg_data[THR_W-1:0];
				CFG_TIME_MASK: cfg_q.time_mask <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.operation <= op_t'(s_axis_tuser);
			item_s1.channel   <= s_axis_tdata[1:0];
			item_s1.ticks     <= s_axis_tdata[33:2];
			item_s1.param     <= s_axis_tdata[65:34];
		end
	end

	tcat_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.fired;
	assign m_axis_tdata  = {3'b000, res_q.enables, res_q.time_value,
	                        res_q.fired_param, res_q.fired_channel};

	// a fired alarm is always disarmed in the reported enables
	a_fired_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.fired) |->
			!((res_q.fired_channel == 2'd0 && res_q.enables[0]) ||
			  (res_q.fired_channel == 2'd1 && res_q.enables[1]) ||
			  (res_q.fired_channel == 2'd2 && res_q.enables[2])))
		else $error("fired channel still enabled");

	// no fire means no channel or parameter reported
	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.fired) |->
			(res_q.fired_channel == '0 && res_q.fired_param == '0))
		else $error("stale fire fields on quiet result");

	// a held-back item in the input stage is not lost
	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input stage dropped an item");

	// a result reported while stalled stays valid
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> out_valid_q)
		else $error("result lost under stall");

endmodule
